/* rtl/mlps_pkg.sv */
// Shared types and codes for the multilevel priority scheduler.
package mlps_pkg;

  localparam int MAX_LVW = 4;
  localparam int MAX_TW  = 6;

  localparam logic CMD_ADMIT = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [1:0] ST_UNUSED   = 2'd0;
  localparam logic [1:0] ST_READY    = 2'd1;
  localparam logic [1:0] ST_FINISHED = 2'd2;

  localparam logic [1:0] REG_AGING_ENABLE = 2'd0;
  localparam logic [1:0] REG_AGE_LIMIT    = 2'd1;
  localparam logic [1:0] REG_QUANTUM      = 2'd2;

  // One queue update: an optional removal at a level and position, then an
  // optional append of a task to the tail of a level.
  typedef struct packed {
    logic               rm_en;
    logic [MAX_LVW-1:0] rm_lvl;
    logic [MAX_TW-1:0]  rm_pos;
    logic               ap_en;
    logic [MAX_LVW-1:0] ap_lvl;
    logic [MAX_TW-1:0]  ap_task;
  } qop_t;

endpackage

/* rtl/mlps_queue.sv */
// Queue update unit: per-task level and queue position, per-level fill.
module mlps_queue #(
  parameter int LEVELS = 10,
  parameter int TASKS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mlps_pkg::qop_t                op,
  output logic [$clog2(LEVELS)-1:0]     task_lvl [TASKS],
  output logic [$clog2(TASKS)-1:0]      task_pos [TASKS],
  output logic [$clog2(TASKS+1)-1:0]    fill     [LEVELS]
);
  import mlps_pkg::*;

  localparam int LVW = $clog2(LEVELS);
  localparam int TW  = $clog2(TASKS);
  localparam int FW  = $clog2(TASKS+1);

  logic [LVW-1:0] lvl_r [TASKS];
  logic [LVW-1:0] lvl_nxt [TASKS];
  logic [TW-1:0]  pos_r [TASKS];
  logic [TW-1:0]  pos_nxt [TASKS];
  logic [FW-1:0]  fill_r [LEVELS];
  logic [FW-1:0]  fill_nxt [LEVELS];
  logic [LVW-1:0] rm_l;
  logic [LVW-1:0] ap_l;
  logic [TW-1:0]  rm_p;
  logic [TW-1:0]  ap_t;
  logic [FW-1:0]  tail;

  assign rm_l = LVW'(op.rm_lvl);
  assign ap_l = LVW'(op.ap_lvl);
  assign rm_p = TW'(op.rm_pos);
  assign ap_t = TW'(op.ap_task);

  // The appended task lands behind whatever is left after the removal.
  assign tail = fill_r[ap_l] - FW'(op.rm_en && rm_l == ap_l);

  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      fill_nxt[l] = fill_r[l] - FW'(op.rm_en && rm_l == LVW'(l))
                              + FW'(op.ap_en && ap_l == LVW'(l));
    end
    for (int k = 0; k < TASKS; k++) begin
      lvl_nxt[k] = lvl_r[k];
      pos_nxt[k] = pos_r[k];
      if (op.ap_en && ap_t == TW'(k)) begin
        lvl_nxt[k] = ap_l;
        pos_nxt[k] = TW'(tail);
      end else if (op.rm_en && lvl_r[k] == rm_l && pos_r[k] > rm_p) begin
        pos_nxt[k] = pos_r[k] - TW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LEVELS; l++) fill_r[l] <= '0;
    end else begin
      for (int l = 0; l < LEVELS; l++) fill_r[l] <= fill_nxt[l];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < TASKS; k++) begin
      lvl_r[k] <= lvl_nxt[k];
      pos_r[k] <= pos_nxt[k];
    end
  end

  assign task_lvl = lvl_r;
  assign task_pos = pos_r;
  assign fill     = fill_r;

endmodule

/* rtl/multilevel_priority_scheduler.sv */
// Top level of the multilevel priority scheduler: sequencer and task tables.
// An admit word gives no result and does not leave the idle state. A tick word walks the
// task table once per task for aging (only when aging is enabled and the tick
// count has reached the age limit), walks it once more to find the head of the
// highest non-empty level, then takes a preemption step and a step that runs the
// head. The walks look at one task per cycle, and all queue updates go through
// the single shared queue update unit. The block takes no word while a tick is in
// work; a result waits in the output register, and while an earlier result is
// still held there by a stalled output the run step waits too, which lengthens
// the tick.
module multilevel_priority_scheduler #(
  parameter int LEVELS = 10,
  parameter int TASKS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [3:0]  in_task_id,
  input  logic [3:0]  in_task_level,
  input  logic [15:0] in_burst_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_running_task,
  output logic        out_idle,
  output logic        out_finished,
  output logic [15:0] out_done_tick,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import mlps_pkg::*;

  localparam int LVW = $clog2(LEVELS);
  localparam int TW  = $clog2(TASKS);
  localparam int FW  = $clog2(TASKS+1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_AGE  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_PRE  = 3'd3;
  localparam logic [2:0] S_EXEC = 3'd4;

  logic [2:0]     state_r, state_nxt;
  logic [TW-1:0]  cnt_r, cnt_nxt;
  logic [TW-1:0]  head_r, head_nxt;
  logic           idle_r, idle_nxt;
  logic [15:0]    tick_r, tick_nxt;
  logic           last_v_r, last_v_nxt;
  logic [TW-1:0]  last_r, last_nxt;
  logic [15:0]    rl_r, rl_nxt;
  logic           hls_v_r, hls_v_nxt;
  logic [LVW-1:0] hls_r, hls_nxt;
  logic           aging_en_r;
  logic [15:0]    age_lim_r;
  logic [15:0]    quantum_r;
  logic [1:0]     status_r [TASKS];
  logic [15:0]    rem_r [TASKS];
  logic [15:0]    stamp_r [TASKS];
  logic           out_valid_r, out_valid_nxt;
  logic [3:0]     out_task_r, out_task_nxt;
  logic           out_idle_r, out_idle_nxt;
  logic           out_fin_r, out_fin_nxt;
  logic [15:0]    out_time_r, out_time_nxt;

  logic [TW-1:0]  idx;
  logic [1:0]     rd_status;
  logic [15:0]    rd_rem;
  logic [15:0]    rd_stamp;
  logic [LVW-1:0] rd_lvl;
  logic [TW-1:0]  rd_pos;
  logic           st_we, rem_we, stamp_we;
  logic [1:0]     st_wd;
  logic [15:0]    rem_wd, stamp_wd;
  qop_t           op;
  logic [LVW-1:0] q_lvl [TASKS];
  logic [TW-1:0]  q_pos [TASKS];
  logic [FW-1:0]  q_fill [LEVELS];
  logic [LVW-1:0] sel;
  logic           any;
  logic           in_acc;
  logic           admit_ok;
  logic [15:0]    wait_diff;
  logic [15:0]    rem_new;
  logic [15:0]    rl_new;

  mlps_queue #(.LEVELS(LEVELS), .TASKS(TASKS)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .task_lvl (q_lvl),
    .task_pos (q_pos),
    .fill     (q_fill)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    sel = '0;
    any = 1'b0;
    for (int l = 0; l < LEVELS; l++) begin
      if (q_fill[l] != '0) begin
        sel = LVW'(l);
        any = 1'b1;
      end
    end
  end

  always_comb begin
    case (state_r)
      S_IDLE:  idx = TW'(in_task_id);
      S_AGE:   idx = cnt_r;
      S_SCAN:  idx = cnt_r;
      S_PRE:   idx = last_r;
      S_EXEC:  idx = head_r;
      default: idx = cnt_r;
    endcase
  end

  assign rd_status = status_r[idx];
  assign rd_rem    = rem_r[idx];
  assign rd_stamp  = stamp_r[idx];
  assign rd_lvl    = q_lvl[idx];
  assign rd_pos    = q_pos[idx];
  assign wait_diff = tick_r - rd_stamp;
  assign rem_new   = rd_rem - 16'd1;

  assign admit_ok = (32'(in_task_id) < TASKS) && (32'(in_task_level) < LEVELS) &&
                    (in_burst_length != 16'd0) && (rd_status != ST_READY);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    head_nxt      = head_r;
    idle_nxt      = idle_r;
    tick_nxt      = tick_r;
    last_v_nxt    = last_v_r;
    last_nxt      = last_r;
    rl_nxt        = rl_r;
    hls_v_nxt     = hls_v_r;
    hls_nxt       = hls_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_task_nxt  = out_task_r;
    out_idle_nxt  = out_idle_r;
    out_fin_nxt   = out_fin_r;
    out_time_nxt  = out_time_r;
    st_we         = 1'b0;
    st_wd         = ST_UNUSED;
    rem_we        = 1'b0;
    rem_wd        = '0;
    stamp_we      = 1'b0;
    stamp_wd      = '0;
    op            = '0;
    rl_new        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_cmd == CMD_ADMIT) begin
          if (admit_ok) begin
            if (!hls_v_r || 32'(in_task_level) > 32'(hls_r)) begin
              hls_v_nxt = 1'b1;
              hls_nxt   = LVW'(in_task_level);
            end
            st_we      = 1'b1;
            st_wd      = ST_READY;
            rem_we     = 1'b1;
            rem_wd     = in_burst_length;
            stamp_we   = 1'b1;
            stamp_wd   = tick_r;
            op.ap_en   = 1'b1;
            op.ap_lvl  = MAX_LVW'(in_task_level);
            op.ap_task = MAX_TW'(idx);
          end
        end else if (in_acc) begin
          cnt_nxt = '0;
          if (aging_en_r && tick_r >= age_lim_r) state_nxt = S_AGE;
          else state_nxt = S_SCAN;
        end
      end
      S_AGE: begin
        if (rd_status == ST_READY && wait_diff == age_lim_r && hls_v_r &&
            rd_lvl < hls_r) begin
          stamp_we   = 1'b1;
          stamp_wd   = tick_r;
          op.rm_en   = 1'b1;
          op.rm_lvl  = MAX_LVW'(rd_lvl);
          op.rm_pos  = MAX_TW'(rd_pos);
          op.ap_en   = 1'b1;
          op.ap_lvl  = MAX_LVW'(rd_lvl + LVW'(1));
          op.ap_task = MAX_TW'(cnt_r);
        end
        if (cnt_r == TW'(TASKS-1)) begin
          cnt_nxt   = '0;
          state_nxt = S_SCAN;
        end else begin
          cnt_nxt = cnt_r + TW'(1);
        end
      end
      S_SCAN: begin
        if (rd_status == ST_READY && rd_lvl == sel && rd_pos == '0) head_nxt = cnt_r;
        if (cnt_r == TW'(TASKS-1)) begin
          idle_nxt  = !any;
          state_nxt = S_PRE;
        end else begin
          cnt_nxt = cnt_r + TW'(1);
        end
      end
      S_PRE: begin
        // A preempted task moves behind its level only if it still leads it.
        if (!idle_r && last_v_r && last_r != head_r && rl_r < quantum_r &&
            rd_status == ST_READY && rd_pos == '0) begin
          op.rm_en   = 1'b1;
          op.rm_lvl  = MAX_LVW'(rd_lvl);
          op.rm_pos  = '0;
          op.ap_en   = 1'b1;
          op.ap_lvl  = MAX_LVW'(rd_lvl);
          op.ap_task = MAX_TW'(last_r);
        end
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          tick_nxt      = tick_r + 16'd1;
          out_task_nxt  = '0;
          out_idle_nxt  = idle_r;
          out_fin_nxt   = 1'b0;
          out_time_nxt  = '0;
          if (!idle_r) begin
            out_task_nxt = 4'(head_r);
            rem_we       = 1'b1;
            rem_wd       = rem_new;
            stamp_we     = 1'b1;
            stamp_wd     = tick_r + 16'd1;
            if (!last_v_r || last_r != head_r) rl_new = 16'd1;
            else if (rl_r != 16'hFFFF) rl_new = rl_r + 16'd1;
            else rl_new = rl_r;
            last_v_nxt = 1'b1;
            last_nxt   = head_r;
            rl_nxt     = rl_new;
            if (rem_new == 16'd0) begin
              st_we        = 1'b1;
              st_wd        = ST_FINISHED;
              op.rm_en     = 1'b1;
              op.rm_lvl    = MAX_LVW'(sel);
              op.rm_pos    = '0;
              out_fin_nxt  = 1'b1;
              out_time_nxt = tick_r + 16'd1;
              last_v_nxt   = 1'b0;
              rl_nxt       = '0;
            end else if (rl_new >= quantum_r) begin
              op.rm_en   = 1'b1;
              op.rm_lvl  = MAX_LVW'(sel);
              op.rm_pos  = '0;
              op.ap_en   = 1'b1;
              op.ap_lvl  = MAX_LVW'(sel);
              op.ap_task = MAX_TW'(head_r);
              last_v_nxt = 1'b0;
              rl_nxt     = '0;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      tick_r      <= '0;
      last_v_r    <= 1'b0;
      rl_r        <= '0;
      hls_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      aging_en_r  <= 1'b0;
      age_lim_r   <= 16'd100;
      quantum_r   <= 16'd4;
      for (int k = 0; k < TASKS; k++) status_r[k] <= ST_UNUSED;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      tick_r      <= tick_nxt;
      last_v_r    <= last_v_nxt;
      rl_r        <= rl_nxt;
      hls_v_r     <= hls_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (st_we) status_r[idx] <= st_wd;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_AGING_ENABLE: aging_en_r <= cfg_data[0];
          REG_AGE_LIMIT:    age_lim_r  <= cfg_data;
          REG_QUANTUM:      quantum_r  <= cfg_data;
          default:          ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    head_r     <= head_nxt;
    idle_r     <= idle_nxt;
    last_r     <= last_nxt;
    hls_r      <= hls_nxt;
    out_task_r <= out_task_nxt;
    out_idle_r <= out_idle_nxt;
    out_fin_r  <= out_fin_nxt;
    out_time_r <= out_time_nxt;
    if (rem_we) rem_r[idx] <= rem_wd;
    if (stamp_we) stamp_r[idx] <= stamp_wd;
  end

  assign out_valid        = out_valid_r;
  assign out_running_task = out_task_r;
  assign out_idle         = out_idle_r;
  assign out_finished     = out_fin_r;
  assign out_done_tick    = out_time_r;

`ifndef NO_ASSERTIONS
  a_idle_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_idle |-> !out_finished && out_running_task == 4'd0)
    else $error("idle word carries a task");
  a_word_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_EXEC)
    else $error("result word raised outside the run step");
  a_admit_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_cmd == CMD_ADMIT |=> state_r == S_IDLE)
    else $error("admit left the sequencer busy");
  a_pre_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PRE |-> $past(state_r) == S_SCAN)
    else $error("preemption step entered without a head search");
`endif

endmodule
